// ----- hw/rtl/cca_pkg.sv -----
// Package for the cluster chain allocator: table geometry, action and status
// codes, register map and the command/status structs between controller and datapath.
// No dependencies.
package cca_pkg;

    localparam int NUM_ENTRIES = 4096;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int WORD_W      = 32;
    localparam int EIU_W       = 13;
    localparam int FS_W        = 12;
    localparam int CL_W        = 12;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [WORD_W-1:0] END_MARK = '1;

    localparam logic [1:0] ACT_FORMAT = 2'd0;
    localparam logic [1:0] ACT_ALLOC  = 2'd1;
    localparam logic [1:0] ACT_EXTEND = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic REG_ENTRIES_IN_USE = 1'b0;
    localparam logic REG_FREE_START     = 1'b1;

    localparam logic [EIU_W-1:0] EIU_RESET = 13'd4096;
    localparam logic [FS_W-1:0]  FS_RESET  = 12'd0;

    typedef struct packed {
        logic accept;
        logic fmt_step;
        logic alloc_link;
        logic alloc_end;
        logic ext_link;
        logic ext_end;
        logic read_cap;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic op_ok;
        logic fmt_empty;
        logic fmt_last;
    } t_dp_stat;

endpackage

// ----- hw/rtl/cca_in_if.sv -----
// Input channel of the cluster chain allocator: valid/ready plus one request.
// Depends on cca_pkg.
interface cca_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic [cca_pkg::CL_W-1:0] prev_cluster;
    logic [cca_pkg::CL_W-1:0] next_cluster;

    modport source (output valid, output action, output prev_cluster,
                    output next_cluster, input ready);
    modport sink   (input valid, input action, input prev_cluster,
                    input next_cluster, output ready);
endinterface

// ----- hw/rtl/cca_out_if.sv -----
// Output channel of the cluster chain allocator: valid/ready plus one result.
// Depends on cca_pkg.
interface cca_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [cca_pkg::WORD_W-1:0] allocated;
    logic [cca_pkg::WORD_W-1:0] entry_value;
    logic [cca_pkg::WORD_W-1:0] free_head_out;

    modport source (output valid, output status, output allocated,
                    output entry_value, output free_head_out, input ready);
    modport sink   (input valid, input status, input allocated,
                    input entry_value, input free_head_out, output ready);
endinterface

// ----- hw/rtl/cluster_chain_allocator.sv -----
// Top level of the cluster chain allocator: configuration registers, controller
// and datapath. Depends on cca_pkg, cca_in_if, cca_out_if, cca_regs, cca_ctrl, cca_dpath.
//
//   Channel   Direction  Protocol       Contents
//   i_in      in         valid/ready    action, prev_cluster, next_cluster
//   o_out     out        valid/ready    status, allocated, entry_value, free_head_out
//   APB       in/out     psel/penable   entries_in_use (0x0), free_start (0x4)
//
// One request at a time, limited by the single write port of the link table RAM.
// Read captures one table word; allocate and extend each write two table entries; a rejected
// request writes nothing; format writes min(entries_in_use, 4096) entries, one entry per cycle.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset is synchronous; the free head resets to all ones, the table is not cleared.
module cluster_chain_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cca_in_if.sink                      i_in,
    cca_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cca_pkg::PADDR_W-1:0] paddr,
    input  logic [cca_pkg::PDATA_W-1:0] pwdata,
    output logic [cca_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic [cca_pkg::EIU_W-1:0] entries_in_use;
    logic [cca_pkg::FS_W-1:0]  free_start;
    cca_pkg::t_dp_cmd          cmd;
    cca_pkg::t_dp_stat         stat;
    logic                      in_ready;
    logic                      out_valid;

    cca_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_entries_in_use (entries_in_use),
        .o_free_start     (free_start)
    );

    cca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_action    (i_in.action),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    cca_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_action         (i_in.action),
        .i_prev_cluster   (i_in.prev_cluster),
        .i_next_cluster   (i_in.next_cluster),
        .i_entries_in_use (entries_in_use),
        .i_free_start     (free_start),
        .o_status         (o_out.status),
        .o_allocated      (o_out.allocated),
        .o_entry_value    (o_out.entry_value),
        .o_free_head_out  (o_out.free_head_out)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

// ----- hw/rtl/cca_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/cca_regs.sv -----
// APB-style configuration registers: entries_in_use and free_start.
// Depends on cca_pkg.
module cca_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cca_pkg::PADDR_W-1:0] paddr,
    input  logic [cca_pkg::PDATA_W-1:0] pwdata,
    output logic [cca_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [cca_pkg::EIU_W-1:0]   o_entries_in_use,
    output logic [cca_pkg::FS_W-1:0]    o_free_start
);

    logic [cca_pkg::EIU_W-1:0] r_entries_in_use;
    logic [cca_pkg::FS_W-1:0]  r_free_start;
    logic                      wr_en;

    // Only the register-select bit is decoded; byte offsets are ignored.
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= cca_pkg::EIU_RESET;
            r_free_start     <= cca_pkg::FS_RESET;
        end else if (wr_en) begin
            if (paddr[2] == cca_pkg::REG_ENTRIES_IN_USE) begin
                r_entries_in_use <= pwdata[cca_pkg::EIU_W-1:0];
            end else begin
                r_free_start <= pwdata[cca_pkg::FS_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == cca_pkg::REG_ENTRIES_IN_USE) begin
            prdata = cca_pkg::PDATA_W'(r_entries_in_use);
        end else begin
            prdata = cca_pkg::PDATA_W'(r_free_start);
        end
    end

    assign pready           = 1'b1;
    assign o_entries_in_use = r_entries_in_use;
    assign o_free_start     = r_free_start;

endmodule

// ----- hw/rtl/cca_dpath.sv -----
// Datapath: link table RAM, free head, format counter, request and result registers.
// Depends on cca_pkg and cca_ram.
module cca_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cca_pkg::t_dp_cmd           i_cmd,
    output cca_pkg::t_dp_stat          o_stat,
    input  logic [1:0]                 i_action,
    input  logic [cca_pkg::CL_W-1:0]   i_prev_cluster,
    input  logic [cca_pkg::CL_W-1:0]   i_next_cluster,
    input  logic [cca_pkg::EIU_W-1:0]  i_entries_in_use,
    input  logic [cca_pkg::FS_W-1:0]   i_free_start,
    output logic [1:0]                 o_status,
    output logic [cca_pkg::WORD_W-1:0] o_allocated,
    output logic [cca_pkg::WORD_W-1:0] o_entry_value,
    output logic [cca_pkg::WORD_W-1:0] o_free_head_out
);

    logic [cca_pkg::WORD_W-1:0] r_free_head;
    logic [cca_pkg::CNT_W-1:0]  r_cnt;
    logic [cca_pkg::IDX_W-1:0]  r_prev;
    logic [cca_pkg::IDX_W-1:0]  r_next;
    logic [cca_pkg::IDX_W-1:0]  r_taken;
    logic [1:0]                 r_status;
    logic [cca_pkg::WORD_W-1:0] r_alloc;
    logic [cca_pkg::WORD_W-1:0] r_entry;

    logic [1:0]                 r_o_status;
    logic [cca_pkg::WORD_W-1:0] r_o_alloc;
    logic [cca_pkg::WORD_W-1:0] r_o_entry;
    logic [cca_pkg::WORD_W-1:0] r_o_head;

    logic [1:0]                 in_status;
    logic                       prev_bad;
    logic                       next_bad;
    logic                       head_bad;
    logic [cca_pkg::CNT_W-1:0]  fmt_len;
    logic                       fmt_last;
    logic                       we;
    logic [cca_pkg::IDX_W-1:0]  waddr;
    logic [cca_pkg::WORD_W-1:0] wdata;
    logic [cca_pkg::IDX_W-1:0]  raddr;
    logic [cca_pkg::WORD_W-1:0] rdata;

    assign prev_bad = 32'(i_prev_cluster) >= 32'(cca_pkg::NUM_ENTRIES);
    assign next_bad = 32'(i_next_cluster) >= 32'(cca_pkg::NUM_ENTRIES);
    assign head_bad = r_free_head >= 32'(cca_pkg::NUM_ENTRIES);

    // The empty-list check takes priority over the range checks.
    always_comb begin
        case (i_action)
            cca_pkg::ACT_FORMAT: in_status = cca_pkg::ST_OK;
            cca_pkg::ACT_ALLOC: begin
                if (r_free_head == cca_pkg::END_MARK) begin
                    in_status = cca_pkg::ST_NOSPACE;
                end else if (prev_bad || head_bad) begin
                    in_status = cca_pkg::ST_RANGE;
                end else begin
                    in_status = cca_pkg::ST_OK;
                end
            end
            cca_pkg::ACT_EXTEND: in_status = (prev_bad || next_bad) ? cca_pkg::ST_RANGE
                                                                    : cca_pkg::ST_OK;
            cca_pkg::ACT_READ:   in_status = prev_bad ? cca_pkg::ST_RANGE : cca_pkg::ST_OK;
            default:             in_status = cca_pkg::ST_RANGE;
        endcase
    end

    always_comb begin
        if (32'(i_entries_in_use) >= 32'(cca_pkg::NUM_ENTRIES)) begin
            fmt_len = cca_pkg::CNT_W'(cca_pkg::NUM_ENTRIES);
        end else begin
            fmt_len = cca_pkg::CNT_W'(i_entries_in_use);
        end
    end

    assign fmt_last         = cca_pkg::CNT_W'(r_cnt + 1'b1) == fmt_len;
    assign o_stat.op_ok     = in_status == cca_pkg::ST_OK;
    assign o_stat.fmt_empty = fmt_len == '0;
    assign o_stat.fmt_last  = fmt_last;

    // Reads go out in the accept cycle: the free head for allocate, the index for read.
    assign raddr = (i_action == cca_pkg::ACT_READ) ? cca_pkg::IDX_W'(i_prev_cluster)
                                                   : cca_pkg::IDX_W'(r_free_head);

    always_comb begin
        we    = 1'b1;
        waddr = r_prev;
        wdata = cca_pkg::END_MARK;
        if (i_cmd.fmt_step) begin
            waddr = r_cnt[cca_pkg::IDX_W-1:0];
            wdata = fmt_last ? cca_pkg::END_MARK : cca_pkg::WORD_W'(r_cnt) + 1'b1;
        end else if (i_cmd.alloc_link) begin
            waddr = r_prev;
            wdata = cca_pkg::WORD_W'(r_taken);
        end else if (i_cmd.alloc_end) begin
            waddr = r_taken;
        end else if (i_cmd.ext_link) begin
            waddr = r_prev;
            wdata = cca_pkg::WORD_W'(r_next);
        end else if (i_cmd.ext_end) begin
            waddr = r_next;
        end else begin
            we = 1'b0;
        end
    end

    cca_ram #(
        .WIDTH (cca_pkg::WORD_W),
        .DEPTH (cca_pkg::NUM_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= cca_pkg::END_MARK;
        end else if (i_cmd.accept && i_action == cca_pkg::ACT_FORMAT) begin
            r_free_head <= cca_pkg::WORD_W'(i_free_start);
        end else if (i_cmd.alloc_link) begin
            r_free_head <= rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cnt    <= '0;
            r_prev   <= cca_pkg::IDX_W'(i_prev_cluster);
            r_next   <= cca_pkg::IDX_W'(i_next_cluster);
            r_taken  <= cca_pkg::IDX_W'(r_free_head);
            r_status <= in_status;
            r_entry  <= '0;
            if (i_action == cca_pkg::ACT_ALLOC && in_status == cca_pkg::ST_OK) begin
                r_alloc <= r_free_head;
            end else begin
                r_alloc <= cca_pkg::END_MARK;
            end
        end else begin
            if (i_cmd.fmt_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.read_cap) begin
                r_entry <= rdata;
            end
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_alloc  <= r_alloc;
            r_o_entry  <= r_entry;
            r_o_head   <= r_free_head;
        end
    end

    assign o_status        = r_o_status;
    assign o_allocated     = r_o_alloc;
    assign o_entry_value   = r_o_entry;
    assign o_free_head_out = r_o_head;

endmodule

// ----- hw/rtl/cca_ctrl.sv -----
// Controller state machine: sequences table reads and writes for each request
// and hands the result to the output register. Depends on cca_pkg.
module cca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_action,
    input  logic              i_out_ready,
    input  cca_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output cca_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FMT,
        S_ALOC_LINK,
        S_ALOC_END,
        S_EXT_LINK,
        S_EXT_END,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_action == cca_pkg::ACT_FORMAT) begin
                        n_state = S_FMT;
                    end else if (!i_stat.op_ok) begin
                        n_state = S_DONE;
                    end else if (i_action == cca_pkg::ACT_ALLOC) begin
                        n_state = S_ALOC_LINK;
                    end else if (i_action == cca_pkg::ACT_EXTEND) begin
                        n_state = S_EXT_LINK;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_FMT: begin
                if (i_stat.fmt_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.fmt_step = 1'b1;
                    if (i_stat.fmt_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ALOC_LINK: begin
                o_cmd.alloc_link = 1'b1;
                n_state          = S_ALOC_END;
            end
            S_ALOC_END: begin
                o_cmd.alloc_end = 1'b1;
                n_state         = S_DONE;
            end
            S_EXT_LINK: begin
                o_cmd.ext_link = 1'b1;
                n_state        = S_EXT_END;
            end
            S_EXT_END: begin
                o_cmd.ext_end = 1'b1;
                n_state       = S_DONE;
            end
            S_READ: begin
                o_cmd.read_cap = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = o_cmd.load_out || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

// ----- test/cca_checker.sv -----
// Checker for the cluster chain allocator: follows register writes and accepted
// requests, predicts each result and compares it with what the block returns.
// Depends on cca_pkg, cca_in_if and cca_out_if.
module cca_checker
    import cca_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    cca_in_if                  i_req,
    cca_out_if                 i_rsp,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] allocated;
        logic [WORD_W-1:0] entry_value;
        logic [WORD_W-1:0] free_head_out;
    } t_chain_result;

    logic [WORD_W-1:0] chain_links [NUM_ENTRIES];
    logic [WORD_W-1:0] free_head;
    logic [EIU_W-1:0]  chain_len_cfg;
    logic [FS_W-1:0]   head_start_cfg;
    t_chain_result     owed_results [$];
    int                fail_cnt = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t: chain check: %s", $time, msg);
        fail_cnt++;
    endtask

    // Updates the table and the free head for one request and returns its result.
    function automatic t_chain_result apply_request(input logic [1:0]      act,
                                                    input logic [CL_W-1:0] pc,
                                                    input logic [CL_W-1:0] nc);
        t_chain_result     res;
        int                n;
        logic [WORD_W-1:0] taken;
        res.status      = ST_OK;
        res.allocated   = END_MARK;
        res.entry_value = '0;
        case (act)
            ACT_FORMAT: begin
                n = (chain_len_cfg > NUM_ENTRIES) ? NUM_ENTRIES : int'(chain_len_cfg);
                for (int i = 0; i < n; i++) chain_links[i] = WORD_W'(i + 1);
                if (n > 0) chain_links[n-1] = END_MARK;
                free_head = WORD_W'(head_start_cfg);
            end
            ACT_ALLOC: begin
                // An empty list wins over any range problem.
                if (free_head == END_MARK) begin
                    res.status = ST_NOSPACE;
                end else if (pc >= NUM_ENTRIES || free_head >= NUM_ENTRIES) begin
                    res.status = ST_RANGE;
                end else begin
                    taken              = free_head;
                    free_head          = chain_links[taken];
                    chain_links[pc]    = taken;
                    chain_links[taken] = END_MARK;
                    res.allocated      = taken;
                end
            end
            ACT_EXTEND: begin
                if (pc >= NUM_ENTRIES || nc >= NUM_ENTRIES) begin
                    res.status = ST_RANGE;
                end else begin
                    chain_links[pc] = WORD_W'(nc);
                    chain_links[nc] = END_MARK;
                end
            end
            default: begin
                if (pc >= NUM_ENTRIES) res.status = ST_RANGE;
                else res.entry_value = chain_links[pc];
            end
        endcase
        res.free_head_out = free_head;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_chain_result seen;
        t_chain_result want;
        if (!i_rst_n) begin
            free_head      = END_MARK;
            chain_len_cfg  = EIU_RESET;
            head_start_cfg = FS_RESET;
            owed_results.delete();
        end else begin
            // Results are checked before this edge's request is predicted, since a
            // result can never belong to a request accepted at the same edge.
            if (i_rsp.valid && i_rsp.ready) begin
                seen.status        = i_rsp.status;
                seen.allocated     = i_rsp.allocated;
                seen.entry_value   = i_rsp.entry_value;
                seen.free_head_out = i_rsp.free_head_out;
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result with none expected, status %0d",
                                              seen.status));
                end else begin
                    want = owed_results.pop_front();
                    if (seen.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  seen.status, want.status));
                    if (seen.allocated !== want.allocated)
                        report_mismatch($sformatf("allocated got %h want %h",
                                                  seen.allocated, want.allocated));
                    if (seen.entry_value !== want.entry_value)
                        report_mismatch($sformatf("entry_value got %h want %h",
                                                  seen.entry_value, want.entry_value));
                    if (seen.free_head_out !== want.free_head_out)
                        report_mismatch($sformatf("free_head_out got %h want %h",
                                                  seen.free_head_out, want.free_head_out));
                end
            end
            if (i_req.valid && i_req.ready) begin
                want = apply_request(i_req.action, i_req.prev_cluster, i_req.next_cluster);
                owed_results.push_back(want);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE)
                    chain_len_cfg = i_pwdata[EIU_W-1:0];
                else if (i_paddr[PADDR_W-1:2] == REG_FREE_START)
                    head_start_cfg = i_pwdata[FS_W-1:0];
            end
        end
        o_pending    <= owed_results.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ----- test/cluster_chain_allocator_tb.sv -----
// Testbench top for the cluster chain allocator: clock, reset, register writes,
// request stimulus with bursts and gaps, result back-pressure and the verdict.
// Depends on cca_pkg, cca_in_if, cca_out_if, cca_checker and the block itself.
module cluster_chain_allocator_tb;
    import cca_pkg::*;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int HOLD_CYCLES     = 400;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic               pready;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               hold_request;
    int                 mismatches;
    int                 results_owed;
    int                 burst_left;

    cca_in_if  req_if();
    cca_out_if rsp_if();

    cluster_chain_allocator u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cca_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (mismatches),
        .o_pending    (results_owed)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #12_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side: switches between stall patterns now and then, and honors one
    // long hold-off on request so that the block backs up into its input.
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       period;
        int       tick;
        logic     hold_done;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        period    = 2;
        tick      = 0;
        hold_done = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            tick++;
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 150);
                    period    = $urandom_range(2, 7);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   rsp_if.ready <= 1'b1;
                    RX_RANDOM: rsp_if.ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   rsp_if.ready <= (tick % period == 0);
                endcase
            end
        end
    end

    // Offers one request, after a random gap when a burst has run out, and
    // returns at the edge where the transaction happens.
    task automatic send_request(input logic [1:0]      act,
                                input logic [CL_W-1:0] pc,
                                input logic [CL_W-1:0] nc);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid        <= 1'b1;
        req_if.action       <= act;
        req_if.prev_cluster <= pc;
        req_if.next_cluster <= nc;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    // The checker's count is registered, so the task lets it update before trusting it.
    task automatic drain_results;
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
    endtask

    task automatic write_register(input logic reg_sel, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly clusters near the start of the table, sometimes the extremes, the middle or anywhere.
    function automatic logic [CL_W-1:0] pick_cluster(input int win);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return CL_W'($urandom_range(0, win));
        if (r < 82) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return CL_W'(NUM_ENTRIES / 2);
                default: return CL_W'(NUM_ENTRIES / 2 - 1);
            endcase
        end
        return CL_W'($urandom_range(0, NUM_ENTRIES - 1));
    endfunction

    task automatic run_phase(input int eiu, input int fs, input int count);
        int         n;
        int         win;
        int         r;
        logic [1:0] act;
        write_register(REG_ENTRIES_IN_USE, PDATA_W'(eiu));
        write_register(REG_FREE_START, PDATA_W'(fs));
        n   = (eiu > NUM_ENTRIES) ? NUM_ENTRIES : eiu;
        win = (n < 8) ? 7 : (n > 64) ? 63 : n - 1;
        send_request(ACT_FORMAT, pick_cluster(win), pick_cluster(win));
        for (int k = 1; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 6)       act = ACT_FORMAT;
            else if (r < 50) act = ACT_ALLOC;
            else if (r < 68) act = ACT_EXTEND;
            else             act = ACT_READ;
            send_request(act, pick_cluster(win), pick_cluster(win));
        end
        drain_results();
    endtask

    initial begin
        int eiu_pick;
        int fs_pick;
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_if.valid        <= 1'b0;
        req_if.action       <= ACT_READ;
        req_if.prev_cluster <= '0;
        req_if.next_cluster <= '0;
        hold_request        <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: the free list starts empty and the table is unwritten,
        // so only entries written by the self-linking extend are read before format.
        send_request(ACT_ALLOC, 12'd5, 12'd0);
        send_request(ACT_EXTEND, 12'd3, 12'd3);
        send_request(ACT_READ, 12'd3, 12'd0);
        send_request(ACT_FORMAT, 12'd0, 12'd0);
        send_request(ACT_READ, 12'd0, 12'hFFF);
        send_request(ACT_READ, 12'hFFF, 12'd0);
        send_request(ACT_ALLOC, 12'hFFF, 12'd0);
        send_request(ACT_ALLOC, 12'd1, 12'd0);
        send_request(ACT_READ, 12'd1, 12'd0);
        send_request(ACT_EXTEND, 12'hFFF, 12'd0);
        send_request(ACT_EXTEND, 12'd7, 12'd7);
        send_request(ACT_READ, 12'd7, 12'd0);
        send_request(ACT_READ, 12'hFFF, 12'hFFF);
        drain_results();

        // Two-entry chain: two allocations empty the list, the third finds no space.
        write_register(REG_ENTRIES_IN_USE, PDATA_W'(2));
        write_register(REG_FREE_START, PDATA_W'(0));
        send_request(ACT_FORMAT, 12'd0, 12'd0);
        send_request(ACT_ALLOC, 12'd100, 12'd0);
        send_request(ACT_ALLOC, 12'd0, 12'd0);
        send_request(ACT_ALLOC, 12'd1, 12'd0);
        send_request(ACT_READ, 12'd0, 12'd0);
        drain_results();

        // A zero-length format only loads the head.
        write_register(REG_ENTRIES_IN_USE, PDATA_W'(0));
        write_register(REG_FREE_START, PDATA_W'(NUM_ENTRIES - 1));
        send_request(ACT_FORMAT, 12'd0, 12'd0);
        send_request(ACT_ALLOC, 12'd0, 12'd0);
        drain_results();

        // A length beyond the table is clamped to the table size.
        write_register(REG_ENTRIES_IN_USE, PDATA_W'(8191));
        send_request(ACT_FORMAT, 12'd0, 12'd0);
        send_request(ACT_READ, 12'hFFF, 12'd0);
        send_request(ACT_ALLOC, 12'hFFF, 12'd0);
        send_request(ACT_ALLOC, 12'd9, 12'd0);
        drain_results();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                1: begin
                    eiu_pick = NUM_ENTRIES;
                    fs_pick  = $urandom_range(0, NUM_ENTRIES - 1);
                end
                4: begin
                    eiu_pick = $urandom_range(NUM_ENTRIES + 1, 8191);
                    fs_pick  = $urandom_range(0, NUM_ENTRIES - 1);
                end
                6: begin
                    eiu_pick = $urandom_range(0, 1);
                    fs_pick  = $urandom_range(0, 7);
                end
                default: begin
                    eiu_pick = $urandom_range(2, 40);
                    fs_pick  = ($urandom_range(0, 3) == 0) ?
                               $urandom_range(0, NUM_ENTRIES - 1) :
                               $urandom_range(0, eiu_pick - 1);
                end
            endcase
            if (p == 3) hold_request <= 1'b1;
            run_phase(eiu_pick, fs_pick, ITEMS_PER_PHASE);
        end

        repeat (16) @(posedge clk);
        if (mismatches == 0 && results_owed == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
